>>> rtl/tdre_pkg.sv
`timescale 1ns / 1ps
package tdre_pkg;

  // input item kinds
  localparam logic IN_START = 1'b0;
  localparam logic IN_BYTE  = 1'b1;

  // TFTP opcodes
  localparam logic [7:0] OP_DATA = 8'd3;
  localparam logic [7:0] OP_ACK  = 8'd4;
  localparam logic [7:0] OP_ERR  = 8'd5;

  localparam logic [9:0] HEADER_LEN = 10'd4;
  localparam logic [9:0] POS_MAX    = 10'd1023;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_ACK    = 2'd1,
    KIND_STATUS = 2'd2
  } out_kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REMOTE = 2'd1,
    ST_PROTO  = 2'd2
  } status_e;

  // one queue entry: everything the back end emits for one input transaction
  typedef struct packed {
    logic        has_data;
    logic [7:0]  data_byte;
    logic        has_ack;
    logic [15:0] blk_num;
    logic        has_status;
    status_e     status;
    logic [31:0] bytes;
    logic [15:0] blocks_old;
    logic [15:0] blocks_new;
  } cmd_t;

  // push/pop side status of the command queue
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

>>> rtl/tdre_in_if.sv
`timescale 1ns / 1ps
interface tdre_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] in_byte;
  logic       end_of_datagram;

  modport source (output valid, kind, in_byte, end_of_datagram, input ready);
  modport sink   (input valid, kind, in_byte, end_of_datagram, output ready);
endinterface

>>> rtl/tdre_out_if.sv
`timescale 1ns / 1ps
interface tdre_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic [1:0]  status;
  logic [31:0] total_bytes;
  logic [15:0] total_blocks;
  logic        last;

  modport source (output valid, out_kind, out_byte, status, total_bytes, total_blocks, last,
                  input ready);
  modport sink   (input valid, out_kind, out_byte, status, total_bytes, total_blocks, last,
                  output ready);
endinterface

>>> rtl/tdre_front.sv
`timescale 1ns / 1ps
module tdre_front #(
  parameter int MAX_BLOCK = 512
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [9:0]           block_size_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 kind_i,
  input  logic [7:0]           in_byte_i,
  input  logic                 end_of_datagram_i,
  input  tdre_pkg::queue_stat_t q_stat_i,
  output logic                 push_o,
  output tdre_pkg::cmd_t       cmd_o
);
  import tdre_pkg::*;

  localparam logic [10:0] MaxBlk = 11'(MAX_BLOCK);

  logic [9:0]  pos_q, pos_d;
  logic [7:0]  opcode_q, opcode_d;
  logic [15:0] blk_q, blk_d;
  logic [15:0] acc_blocks_q, acc_blocks_d;
  logic [31:0] acc_bytes_q, acc_bytes_d;
  logic        is_new_q, is_new_d;
  logic        done_q, done_d;

  logic        accept;
  logic [10:0] eff;
  logic [9:0]  pos_nxt;
  logic [9:0]  pay_idx;
  logic [9:0]  plen;
  logic        full_blk;
  logic        inc;
  logic        emit;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  assign eff      = ({1'b0, block_size_i} > MaxBlk) ? MaxBlk : {1'b0, block_size_i};
  assign pos_nxt  = (pos_q < POS_MAX) ? pos_q + 10'd1 : POS_MAX;
  assign pay_idx  = pos_q - HEADER_LEN;
  assign plen     = pos_nxt - HEADER_LEN;
  assign full_blk = (pos_nxt == POS_MAX) || ({1'b0, plen} >= eff);

  always_comb begin
    pos_d        = pos_q;
    opcode_d     = opcode_q;
    blk_d        = blk_q;
    acc_blocks_d = acc_blocks_q;
    acc_bytes_d  = acc_bytes_q;
    is_new_d     = is_new_q;
    done_d       = done_q;
    inc          = 1'b0;
    emit         = 1'b0;
    cmd_o        = '0;

    if (accept && kind_i == IN_START) begin
      pos_d        = '0;
      opcode_d     = '0;
      blk_d        = '0;
      acc_blocks_d = '0;
      acc_bytes_d  = '0;
      is_new_d     = 1'b0;
      done_d       = 1'b0;
    end else if (accept && !done_q) begin
      case (pos_q)
        10'd0: is_new_d = 1'b0;
        10'd1: opcode_d = in_byte_i;
        10'd2: blk_d = {in_byte_i, blk_q[7:0]};
        10'd3: begin
          blk_d    = {blk_q[15:8], in_byte_i};
          is_new_d = (opcode_q == OP_DATA) && ({blk_q[15:8], in_byte_i} > acc_blocks_q);
        end
        default: begin
          if (opcode_q == OP_DATA && is_new_q && ({1'b0, pay_idx} < eff)) begin
            if (acc_bytes_q != 32'hFFFF_FFFF) acc_bytes_d = acc_bytes_q + 32'd1;
            cmd_o.has_data  = 1'b1;
            cmd_o.data_byte = in_byte_i;
          end
        end
      endcase

      if (!end_of_datagram_i) begin
        pos_d = pos_nxt;
      end else begin
        pos_d    = '0;
        is_new_d = 1'b0;
        if (pos_nxt < HEADER_LEN) begin
          done_d           = 1'b1;
          cmd_o.has_status = 1'b1;
          cmd_o.status     = ST_PROTO;
        end else if (opcode_q == OP_DATA) begin
          // payload length > 0 implies the header is complete, so is_new_q is current
          inc           = is_new_q && (pos_q >= HEADER_LEN);
          cmd_o.has_ack = 1'b1;
          if (!full_blk) begin
            done_d           = 1'b1;
            cmd_o.has_status = 1'b1;
            cmd_o.status     = ST_OK;
          end
        end else begin
          done_d           = 1'b1;
          cmd_o.has_status = 1'b1;
          cmd_o.status     = (opcode_q == OP_ERR) ? ST_REMOTE : ST_PROTO;
        end
      end
      emit = cmd_o.has_data || end_of_datagram_i;
    end

    if (inc) acc_blocks_d = acc_blocks_q + 16'd1;
    cmd_o.blk_num    = blk_d;
    cmd_o.bytes      = acc_bytes_d;
    cmd_o.blocks_old = acc_blocks_q;
    cmd_o.blocks_new = acc_blocks_d;
  end

  assign push_o = emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      opcode_q     <= '0;
      blk_q        <= '0;
      acc_blocks_q <= '0;
      acc_bytes_q  <= '0;
      is_new_q     <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      opcode_q     <= opcode_d;
      blk_q        <= blk_d;
      acc_blocks_q <= acc_blocks_d;
      acc_bytes_q  <= acc_bytes_d;
      is_new_q     <= is_new_d;
      done_q       <= done_d;
    end
  end

endmodule

>>> rtl/tdre_queue.sv
`timescale 1ns / 1ps
module tdre_queue #(
  parameter int DEPTH = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  tdre_pkg::cmd_t        cmd_i,
  input  logic                  pop_i,
  output tdre_pkg::cmd_t        head_o,
  output tdre_pkg::queue_stat_t stat_o
);
  import tdre_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign stat_o.full  = (cnt_q == DepthC);
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> rtl/tdre_back.sv
`timescale 1ns / 1ps
module tdre_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tdre_pkg::cmd_t        head_i,
  input  tdre_pkg::queue_stat_t q_stat_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            out_kind_o,
  output logic [7:0]            out_byte_o,
  output logic [1:0]            status_o,
  output logic [31:0]           total_bytes_o,
  output logic [15:0]           total_blocks_o,
  output logic                  last_o
);
  import tdre_pkg::*;

  logic [2:0]  idx_q;
  logic        valid_q;
  out_kind_e   kind_q;
  logic [7:0]  byte_q;
  status_e     status_q;
  logic [31:0] bytes_q;
  logic [15:0] blocks_q;
  logic        last_q;

  logic        load;
  logic [2:0]  n_res;
  logic [2:0]  j;
  logic        is_last;
  out_kind_e   r_kind;
  logic [7:0]  r_byte;
  status_e     r_status;
  logic [15:0] r_blocks;

  assign load  = !q_stat_i.empty && (!valid_q || out_ready_i);
  assign n_res = {2'b00, head_i.has_data} + (head_i.has_ack ? 3'd4 : 3'd0)
               + {2'b00, head_i.has_status};
  assign j       = idx_q - {2'b00, head_i.has_data};
  assign is_last = (idx_q == n_res - 3'd1);
  assign pop_o   = load && is_last;

  always_comb begin
    r_byte   = '0;
    r_status = ST_OK;
    r_blocks = head_i.blocks_new;
    if (head_i.has_data && idx_q == 3'd0) begin
      r_kind   = KIND_DATA;
      r_byte   = head_i.data_byte;
      r_blocks = head_i.blocks_old;
    end else if (head_i.has_ack && j < 3'd4) begin
      r_kind = KIND_ACK;
      case (j[1:0])
        2'd0:    r_byte = 8'd0;
        2'd1:    r_byte = OP_ACK;
        2'd2:    r_byte = head_i.blk_num[15:8];
        default: r_byte = head_i.blk_num[7:0];
      endcase
    end else begin
      r_kind   = KIND_STATUS;
      r_status = head_i.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= is_last ? 3'd0 : idx_q + 3'd1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q   <= r_kind;
      byte_q   <= r_byte;
      status_q <= r_status;
      bytes_q  <= head_i.bytes;
      blocks_q <= r_blocks;
      last_q   <= is_last;
    end
  end

  assign out_valid_o    = valid_q;
  assign out_kind_o     = kind_q;
  assign out_byte_o     = byte_q;
  assign status_o       = status_q;
  assign total_bytes_o  = bytes_q;
  assign total_blocks_o = blocks_q;
  assign last_o         = last_q;

endmodule

>>> rtl/tftp_data_receive_engine.sv
`timescale 1ns / 1ps
// TFTP read-transfer receiver.
// in_i carries one transaction per cycle: a start item (kind 0) that clears the
// counters, or one datagram byte with an end-of-datagram mark. out_o carries file
// data bytes, the four ACK bytes sent at the end of each DATA datagram, and a
// single status result when the transfer ends; last marks the final result of
// each input transaction.
// Throughput: one input transaction per cycle. Results leave at one per cycle while
// out_o.ready is high, so a datagram end that yields up to six results keeps the
// output busy; a 4-entry command queue between the parser and the result sequencer
// absorbs these bursts, and in_i.ready drops only when that queue is full.
// The first result of a transaction passes through the command queue and then the
// output register when the queue is empty and the output is free.
// When out_o.ready is low the output register holds its result, the queue fills
// behind it, and then input is back-pressured.
// Reset clears the counters, the queue and the output valid; block_size resets
// to 512 and is written through the APB port at offset 0.
module tftp_data_receive_engine #(
  parameter int MAX_BLOCK = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tdre_in_if.sink     in_i,
  tdre_out_if.source  out_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);
  import tdre_pkg::*;

  localparam logic ADDR_BLOCK_SIZE = 1'b0;

  logic [9:0]  block_size_q;
  logic        push, pop;
  cmd_t        cmd, head;
  queue_stat_t q_stat;

  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == ADDR_BLOCK_SIZE) ? {22'd0, block_size_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= 10'd512;
    end else if (psel_i && penable_i && pwrite_i && paddr_i[2] == ADDR_BLOCK_SIZE) begin
      block_size_q <= pwdata_i[9:0];
    end
  end

  tdre_front #(
    .MAX_BLOCK(MAX_BLOCK)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .block_size_i     (block_size_q),
    .in_valid_i       (in_i.valid),
    .in_ready_o       (in_i.ready),
    .kind_i           (in_i.kind),
    .in_byte_i        (in_i.in_byte),
    .end_of_datagram_i(in_i.end_of_datagram),
    .q_stat_i         (q_stat),
    .push_o           (push),
    .cmd_o            (cmd)
  );

  tdre_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .cmd_i (cmd),
    .pop_i (pop),
    .head_o(head),
    .stat_o(q_stat)
  );

  tdre_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .q_stat_i      (q_stat),
    .pop_o         (pop),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_kind_o    (out_o.out_kind),
    .out_byte_o    (out_o.out_byte),
    .status_o      (out_o.status),
    .total_bytes_o (out_o.total_bytes),
    .total_blocks_o(out_o.total_blocks),
    .last_o        (out_o.last)
  );

endmodule

>>> rtl/tdre_checker.sv
`timescale 1ns / 1ps
module tdre_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_kind_i,
  input logic [7:0]  out_byte_i,
  input logic [1:0]  status_i,
  input logic [31:0] total_bytes_i,
  input logic [15:0] total_blocks_i,
  input logic        last_i
);
  import tdre_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i)
      && $stable(out_byte_i) && $stable(status_i) && $stable(total_bytes_i)
      && $stable(total_blocks_i) && $stable(last_i))
    else $error("output changed while stalled");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == KIND_STATUS |-> last_i && out_byte_i == 8'd0)
    else $error("status result not final or carries a byte");

  a_payload_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == KIND_DATA || out_kind_i == KIND_ACK) |-> status_i == ST_OK)
    else $error("data or ack result carries a status");

  a_ack_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_kind_i == KIND_ACK && out_byte_i == OP_ACK
      && !last_i |=> out_kind_i == KIND_ACK || !out_valid_i)
    else $error("ack packet interrupted");

endmodule

bind tftp_data_receive_engine tdre_checker u_tdre_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_kind_i    (out_o.out_kind),
  .out_byte_i    (out_o.out_byte),
  .status_i      (out_o.status),
  .total_bytes_i (out_o.total_bytes),
  .total_blocks_i(out_o.total_blocks),
  .last_i        (out_o.last)
);
